[rtl/clrn_pkg.sv]
// Package for the cross-channel response normalization block.
// Holds shared widths, register indexes, state types and the root table.
// Depends on nothing; the cell, power unit, top level and testbench import it.
package clrn_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int SQUARE_W    = 31;
    localparam int SUM_W       = 36;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SIZE = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_SCALE = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BETA_EXP    = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BIAS_OFFSET = 4'd3;

    localparam logic [3:0]  WINDOW_SIZE_RST = 4'd1;
    localparam logic [23:0] ALPHA_SCALE_RST = 24'd1678;
    localparam logic [15:0] BETA_EXP_RST    = 16'd12288;
    localparam logic [23:0] BIAS_OFFSET_RST = 24'd65536;

    typedef struct packed {
        logic [3:0]  size;
        logic [23:0] alpha;
        logic [15:0] beta;
        logic [23:0] bias;
    } norm_cfg_t;

    typedef enum logic [2:0] {
        T_IDLE,
        T_LOAD,
        T_SCAN,
        T_CALC,
        T_PUSH
    } top_state_t;

    typedef enum logic [3:0] {
        P_IDLE,
        P_MUL_LO,
        P_MUL_HI,
        P_SUM,
        P_DIV,
        P_BIAS,
        P_NORM,
        P_LOG_MUL,
        P_LOG_UPD,
        P_BETA,
        P_EXP_SET,
        P_EXP_MUL,
        P_EXP_UPD,
        P_OUT_MUL,
        P_ROUND
    } pwr_state_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] r;
        logic [63:0] b;
        rem = v;
        r   = 64'd0;
        b   = 64'd1 << 62;
        for (int k = 0; k < 32; k++)
        begin
            if (rem >= r + b)
            begin
                rem = rem - (r + b);
                r   = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Entry i is 2^(2^-i) in Q2.30, built by repeated square roots of 2.0.
    function automatic logic [31:0] root_const(input int idx);
        logic [63:0] t;
        t = 64'd2 << 30;
        for (int i = 1; i <= 16; i++)
        begin
            if (i <= idx)
            begin
                t = isqrt64(t << 30);
            end
        end
        return t[31:0];
    endfunction

    localparam logic [31:0] ROOT_TAB [0:16] = '{
        root_const(0),  root_const(1),  root_const(2),  root_const(3),
        root_const(4),  root_const(5),  root_const(6),  root_const(7),
        root_const(8),  root_const(9),  root_const(10), root_const(11),
        root_const(12), root_const(13), root_const(14), root_const(15),
        root_const(16)
    };

endpackage

[rtl/clrn_ifs.sv]
// Channel interfaces of the cross-channel response normalization block.
// Input samples, normalized results and configuration writes.
// Depends on nothing.
interface clrn_in_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] sample;
    logic              last_channel;
    modport source (output valid, sample, last_channel, input ready);
    modport sink (input valid, sample, last_channel, output ready);
endinterface

interface clrn_out_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] normalized;
    logic              last;
    modport source (output valid, normalized, last, input ready);
    modport sink (input valid, normalized, last, output ready);
endinterface

interface clrn_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [23:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/clrn_cell.sv]
// One cell of the channel delay line: a sample and its square.
// Cells hand their contents to the next cell on every accepted transfer.
// Depends on clrn_pkg.
module clrn_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                shift,
    input  logic signed [clrn_pkg::SAMPLE_W-1:0] sample_in,
    input  logic [clrn_pkg::SQUARE_W-1:0]       square_in,
    output logic signed [clrn_pkg::SAMPLE_W-1:0] sample,
    output logic [clrn_pkg::SQUARE_W-1:0]       square
);
    import clrn_pkg::*;

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [SQUARE_W-1:0]        square_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
            square_reg <= '0;
        end
        else if (shift)
        begin
            sample_reg <= sample_in;
            square_reg <= square_in;
        end
    end

    assign sample = sample_reg;
    assign square = square_reg;

endmodule

[rtl/clrn_power.sv]
// Power unit: result = x / (bias + alpha/size * sum)^beta in Q8.8.
// Bit-serial divider, normalizer, log2 by squaring and exp2 by root products;
// the multiplying steps share one registered multiplier. Depends on clrn_pkg.
module clrn_power (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  clrn_pkg::norm_cfg_t                 cfg,
    input  logic [clrn_pkg::SUM_W-1:0]          sum,
    input  logic signed [clrn_pkg::SAMPLE_W-1:0] x,
    output logic                                done,
    output logic signed [clrn_pkg::SAMPLE_W-1:0] result
);
    import clrn_pkg::*;

    pwr_state_t state_reg, state_next;

    logic [5:0]          cnt_reg;
    logic [63:0]         mul_reg;
    logic [41:0]         plo_reg;
    logic [35:0]         num_reg;
    logic [3:0]          rem_reg;
    logic [35:0]         norm_reg;
    logic [5:0]          m_reg;
    logic [30:0]         y_reg;
    logic [15:0]         frac_reg;
    logic                neg_reg;
    logic signed [10:0]  ip_reg;
    logic [15:0]         fr_reg;
    logic [30:0]         r_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic signed [15:0]  x_reg;
    logic signed [15:0]  res_reg;
    logic                done_reg;

    logic [31:0]         mul_a;
    logic [31:0]         mul_b;
    logic [63:0]         mul_full;
    logic signed [6:0]   m_s;
    logic signed [22:0]  lg;
    logic [22:0]         lg_mag;
    logic [16:0]         mag;
    logic [16:0]         cap;
    logic [4:0]          div_try;
    logic                div_bit;
    logic [35:0]         d_sum;
    logic signed [39:0]  bl_s;
    logic signed [25:0]  fl_s;
    logic signed [26:0]  e_s;
    logic [3:0]          fr_idx;
    logic signed [11:0]  sh;
    logic [49:0]         rnd;
    logic [49:0]         full;
    logic [16:0]         res_mag;
    logic signed [15:0]  res_val;

    always_comb
    begin
        m_s     = $signed({1'b0, m_reg}) - 7'sd16;
        lg      = {m_s, frac_reg};
        lg_mag  = lg[22] ? 23'(23'sd0 - lg) : lg;
        mag     = x_reg[15] ? (17'd0 - {x_reg[15], x_reg}) : {1'b0, x_reg};
        cap     = x_reg[15] ? 17'd32768 : 17'd32767;
        div_try = {rem_reg, num_reg[35]};
        div_bit = (div_try >= {1'b0, cfg.size});
        d_sum   = {12'd0, cfg.bias} + num_reg;
        bl_s    = neg_reg ? (40'sd0 - $signed({1'b0, mul_reg[38:0]}))
                          : $signed({1'b0, mul_reg[38:0]});
        fl_s    = 26'(bl_s >>> 14);
        e_s     = 27'sd0 - 27'(fl_s);
        fr_idx  = 4'(5'd16 - cnt_reg[4:0]);
        sh      = 12'sd30 - 12'(ip_reg);
        rnd     = {2'b0, mul_reg[47:0]} + (50'd1 << (sh[5:0] - 6'd1));
        full    = rnd >> sh[5:0];
        if (x_reg == 16'sd0)
        begin
            res_mag = 17'd0;
        end
        else if (sh <= 12'sd0)
        begin
            res_mag = cap;
        end
        else if (sh >= 12'sd50)
        begin
            res_mag = 17'd0;
        end
        else if (full > {33'd0, cap})
        begin
            res_mag = cap;
        end
        else
        begin
            res_mag = full[16:0];
        end
        res_val = x_reg[15] ? 16'(17'd0 - res_mag) : res_mag[15:0];
    end

    // One multiplier serves every multiplying step; its product is registered.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            P_MUL_LO:
            begin
                mul_a = {8'd0, cfg.alpha};
                mul_b = {14'd0, sum_reg[17:0]};
            end
            P_MUL_HI:
            begin
                mul_a = {8'd0, cfg.alpha};
                mul_b = {14'd0, sum_reg[35:18]};
            end
            P_LOG_MUL:
            begin
                mul_a = {1'b0, y_reg};
                mul_b = {1'b0, y_reg};
            end
            P_BETA:
            begin
                mul_a = {16'd0, cfg.beta};
                mul_b = {9'd0, lg_mag};
            end
            P_EXP_MUL:
            begin
                mul_a = {1'b0, r_reg};
                mul_b = ROOT_TAB[cnt_reg[4:0]];
            end
            P_OUT_MUL:
            begin
                mul_a = {15'd0, mag};
                mul_b = {1'b0, r_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_full = mul_a * mul_b;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            P_IDLE:    if (start) state_next = P_MUL_LO;
            P_MUL_LO:  state_next = P_MUL_HI;
            P_MUL_HI:  state_next = P_SUM;
            P_SUM:     state_next = P_DIV;
            P_DIV:     if (cnt_reg == 6'd35) state_next = P_BIAS;
            P_BIAS:    state_next = P_NORM;
            P_NORM:    if (norm_reg[35]) state_next = P_LOG_MUL;
            P_LOG_MUL: state_next = P_LOG_UPD;
            P_LOG_UPD: state_next = (cnt_reg == 6'd15) ? P_BETA : P_LOG_MUL;
            P_BETA:    state_next = P_EXP_SET;
            P_EXP_SET: state_next = P_EXP_MUL;
            P_EXP_MUL: state_next = P_EXP_UPD;
            P_EXP_UPD: state_next = (cnt_reg == 6'd16) ? P_OUT_MUL : P_EXP_MUL;
            P_OUT_MUL: state_next = P_ROUND;
            P_ROUND:   state_next = P_IDLE;
            default:   state_next = P_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == P_ROUND);
        end
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= mul_full;
        case (state_reg)
            P_IDLE:
            begin
                if (start)
                begin
                    sum_reg <= sum;
                    x_reg   <= x;
                end
            end
            P_MUL_HI:
            begin
                plo_reg <= mul_reg[41:0];
            end
            P_SUM:
            begin
                // Dropping the low 24 bits before dividing by size gives the same floor.
                num_reg <= 36'(({18'd0, plo_reg} + {mul_reg[41:0], 18'd0}) >> 24);
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            P_DIV:
            begin
                rem_reg <= div_bit ? 4'(div_try - {1'b0, cfg.size}) : div_try[3:0];
                num_reg <= {num_reg[34:0], div_bit};
                cnt_reg <= cnt_reg + 6'd1;
            end
            P_BIAS:
            begin
                norm_reg <= (d_sum == 36'd0) ? 36'd1 : d_sum;
                m_reg    <= 6'd35;
            end
            P_NORM:
            begin
                if (norm_reg[35])
                begin
                    y_reg    <= norm_reg[35:5];
                    cnt_reg  <= '0;
                    frac_reg <= '0;
                end
                else
                begin
                    norm_reg <= {norm_reg[34:0], 1'b0};
                    m_reg    <= m_reg - 6'd1;
                end
            end
            P_LOG_UPD:
            begin
                if (mul_reg[61])
                begin
                    y_reg    <= mul_reg[61:31];
                    frac_reg <= {frac_reg[14:0], 1'b1};
                end
                else
                begin
                    y_reg    <= mul_reg[60:30];
                    frac_reg <= {frac_reg[14:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 6'd1;
            end
            P_BETA:
            begin
                neg_reg <= lg[22];
            end
            P_EXP_SET:
            begin
                ip_reg  <= e_s[26:16];
                fr_reg  <= e_s[15:0];
                r_reg   <= 31'd1 << 30;
                cnt_reg <= 6'd1;
            end
            P_EXP_UPD:
            begin
                if (fr_reg[fr_idx])
                begin
                    r_reg <= mul_reg[60:30];
                end
                cnt_reg <= cnt_reg + 6'd1;
            end
            P_ROUND:
            begin
                res_reg <= res_val;
            end
            default:
            begin
            end
        endcase
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

[rtl/cross_channel_response_norm.sv]
// Cross-channel local response normalization over a streamed channel vector.
// Depends on clrn_pkg, clrn_ifs, clrn_cell and clrn_power.
//
// Samples of one position enter one transfer at a time and move through a row of
// delay cells. A result leaves once the newest channel of its window is in; the
// last channel releases all remaining results in channel order. Each result goes
// through a load state, a window scan over the channels of its window, the power
// unit and a push state. The power unit holds a 36-step bit-serial divider, a
// normalizing shift, log2 by squaring and exp2 by root products, the last two on
// its one shared multiplier. Input is taken only when no result is being worked
// on; the result register lets the next input in while a result still waits.
// Configuration writes are taken every cycle; writes to the four registers
// restart the current vector.
module cross_channel_response_norm #(
    parameter int MAX_WINDOW = 15
) (
    input logic      clk,
    input logic      rst_n,
    clrn_in_if.sink  in_ch,
    clrn_out_if.source out_ch,
    clrn_cfg_if.sink cfg
);
    import clrn_pkg::*;

    localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam logic [4:0] MW_C     = 5'(MAX_WINDOW);
    localparam logic [4:0] LAST_POS = 5'(MAX_WINDOW - 1);

    top_state_t state_reg, state_next;

    logic [3:0]  win_reg;
    logic [23:0] alpha_reg;
    logic [15:0] beta_reg;
    logic [23:0] bias_reg;
    logic [3:0]  seen_reg;
    logic [3:0]  pending_reg;
    logic [3:0]  work_seen_reg;
    logic [4:0]  p_reg;
    logic [3:0]  left_reg;
    logic        fin_reg;
    logic [4:0]  idx_reg;
    logic [SUM_W-1:0] acc_reg;
    logic signed [15:0] x_reg;
    logic        out_valid_reg;
    logic signed [15:0] out_norm_reg;
    logic        out_last_reg;

    logic signed [SAMPLE_W-1:0] samp [MAX_WINDOW];
    logic [SQUARE_W-1:0]        sq   [MAX_WINDOW];
    logic signed [31:0]         head_sq;

    logic        accept;
    logic        cfg_hit;
    logic [3:0]  size;
    logic [3:0]  ahead;
    logic [3:0]  after;
    logic [3:0]  seen_new;
    logic [3:0]  pend_inc;
    logic [3:0]  pend_new;
    logic [4:0]  lo_pos;
    logic [4:0]  hi_a;
    logic [4:0]  hi_pos;
    logic [4:0]  seen_lim;
    logic signed [15:0] cur_sample;
    logic [SQUARE_W-1:0] cur_square;
    logic [SUM_W-1:0] acc_next;
    logic signed [15:0] x_next;
    logic        scan_end;
    logic        out_free;
    logic        push;
    logic        pwr_done;
    logic signed [15:0] pwr_result;
    norm_cfg_t   ncfg;

    assign accept  = in_ch.valid && in_ch.ready;
    assign head_sq = in_ch.sample * in_ch.sample;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_WINDOW; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                clrn_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .shift     (accept),
                    .sample_in (in_ch.sample),
                    .square_in (head_sq[SQUARE_W-1:0]),
                    .sample    (samp[gi]),
                    .square    (sq[gi])
                );
            end
            else
            begin : g_body
                clrn_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .shift     (accept),
                    .sample_in (samp[gi-1]),
                    .square_in (sq[gi-1]),
                    .sample    (samp[gi]),
                    .square    (sq[gi])
                );
            end
        end
    endgenerate

    always_comb
    begin
        if (win_reg == 4'd0)
        begin
            size = 4'd1;
        end
        else if ({1'b0, win_reg} > MW_C)
        begin
            size = MW_C[3:0];
        end
        else
        begin
            size = win_reg;
        end
        ahead    = (size - 4'd1) >> 1;
        after    = size - 4'd1 - ahead;
        seen_new = (seen_reg == 4'd15) ? seen_reg : seen_reg + 4'd1;
        pend_inc = (pending_reg == 4'd15) ? pending_reg : pending_reg + 4'd1;
        pend_new = ({1'b0, pend_inc} > {1'b0, after} + 5'd1) ? after + 4'd1 : pend_inc;

        // Window of the result in delay-line positions, clipped at both ends.
        lo_pos   = (p_reg > {1'b0, after}) ? p_reg - {1'b0, after} : 5'd0;
        hi_a     = p_reg + {1'b0, ahead};
        seen_lim = {1'b0, work_seen_reg} - 5'd1;
        hi_pos   = hi_a;
        if (hi_pos > seen_lim)
        begin
            hi_pos = seen_lim;
        end
        if (hi_pos > LAST_POS)
        begin
            hi_pos = LAST_POS;
        end

        cur_sample = samp[idx_reg[IW-1:0]];
        cur_square = sq[idx_reg[IW-1:0]];
        acc_next   = acc_reg + {{(SUM_W-SQUARE_W){1'b0}}, cur_square};
        x_next     = (idx_reg == p_reg) ? cur_sample : x_reg;
        scan_end   = (state_reg == T_SCAN) && (idx_reg == hi_pos);
        out_free   = !out_valid_reg || out_ch.ready;
        push       = (state_reg == T_PUSH) && out_free;
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ch.ready = 1'b0;
        case (state_reg)
            T_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (accept && (in_ch.last_channel || pend_new > after))
                begin
                    state_next = T_LOAD;
                end
            end
            T_LOAD:
            begin
                state_next = T_SCAN;
            end
            T_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = T_CALC;
                end
            end
            T_CALC:
            begin
                if (pwr_done)
                begin
                    state_next = T_PUSH;
                end
            end
            T_PUSH:
            begin
                if (out_free)
                begin
                    state_next = (left_reg == 4'd1) ? T_IDLE : T_LOAD;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cfg_hit = 1'b0;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_WINDOW_SIZE, REG_ALPHA_SCALE, REG_BETA_EXP, REG_BIAS_OFFSET:
                    cfg_hit = 1'b1;
                default:
                    cfg_hit = 1'b0;
            endcase
        end
    end

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            win_reg       <= WINDOW_SIZE_RST;
            alpha_reg     <= ALPHA_SCALE_RST;
            beta_reg      <= BETA_EXP_RST;
            bias_reg      <= BIAS_OFFSET_RST;
            seen_reg      <= '0;
            pending_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_WINDOW_SIZE: win_reg   <= cfg.data[3:0];
                    REG_ALPHA_SCALE: alpha_reg <= cfg.data;
                    REG_BETA_EXP:    beta_reg  <= cfg.data[15:0];
                    REG_BIAS_OFFSET: bias_reg  <= cfg.data;
                    default:
                    begin
                    end
                endcase
            end
            if (cfg_hit)
            begin
                seen_reg    <= '0;
                pending_reg <= '0;
            end
            else if (accept)
            begin
                if (in_ch.last_channel)
                begin
                    seen_reg    <= '0;
                    pending_reg <= '0;
                end
                else
                begin
                    seen_reg    <= seen_new;
                    pending_reg <= (pend_new > after) ? pend_new - 4'd1 : pend_new;
                end
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            work_seen_reg <= seen_new;
            fin_reg       <= in_ch.last_channel;
            if (in_ch.last_channel)
            begin
                p_reg    <= {1'b0, pend_new} - 5'd1;
                left_reg <= pend_new;
            end
            else
            begin
                p_reg    <= {1'b0, after};
                left_reg <= 4'd1;
            end
        end
        if (state_reg == T_LOAD)
        begin
            idx_reg <= lo_pos;
            acc_reg <= '0;
        end
        if (state_reg == T_SCAN)
        begin
            idx_reg <= idx_reg + 5'd1;
            acc_reg <= acc_next;
            x_reg   <= x_next;
        end
        if (push)
        begin
            out_norm_reg <= pwr_result;
            out_last_reg <= fin_reg && (p_reg == 5'd0);
            p_reg        <= p_reg - 5'd1;
            left_reg     <= left_reg - 4'd1;
        end
    end

    assign ncfg = '{size: size, alpha: alpha_reg, beta: beta_reg, bias: bias_reg};

    clrn_power u_power (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (scan_end),
        .cfg    (ncfg),
        .sum    (acc_next),
        .x      (x_next),
        .done   (pwr_done),
        .result (pwr_result)
    );

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.normalized = out_norm_reg;
    assign out_ch.last       = out_last_reg;

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 4'd8)
        else $error("pending count exceeds the largest look-ahead");

    a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        pwr_done |-> state_reg == T_CALC)
        else $error("power unit finished outside the wait state");

    a_scan_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == T_SCAN |-> idx_reg <= hi_pos)
        else $error("window scan ran past the window end");

    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> out_ch.valid)
        else $error("result transfer not presented after push");

endmodule

[bench/testbench.sv]
// Testbench for the cross-channel response normalization block.
// Streams channel vectors under several register settings and checks every result.
// Depends on clrn_pkg, the clrn_ifs interfaces and the block's top level.
`timescale 1ns / 100ps

module testbench;
    import clrn_pkg::*;

    typedef struct {
        logic signed [15:0] sample;
        logic               last_channel;
    } channel_item_t;

    typedef struct {
        logic signed [15:0] normalized;
        logic               last;
    } norm_result_t;

    localparam int DEPTH = 15;
    localparam int SETTLE_CYCLES = 400;

    logic clk;
    logic rst_n;

    clrn_in_if  in_if();
    clrn_out_if out_if();
    clrn_cfg_if cfg_if();

    cross_channel_response_norm u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_if),
        .out_ch (out_if),
        .cfg    (cfg_if)
    );

    // Model state of the block.
    logic [3:0]  win_reg;
    logic [23:0] alpha_reg;
    logic [15:0] beta_reg;
    logic [23:0] bias_reg;
    logic [15:0] history [0:DEPTH-1];
    int          seen_count;
    int          waiting_count;
    logic [63:0] root_q [0:16];

    channel_item_t channel_queue [$];
    norm_result_t  expected_results [$];
    channel_item_t offered;
    int items_sent;
    int results_checked;
    int mismatches;
    int stall_left;
    bit stall_done;

    always #5 clk = ~clk;

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = 64'd0;
        for (int k = 31; k >= 0; k--)
        begin
            t = r | (64'd1 << k);
            if (t * t <= v)
            begin
                r = t;
            end
        end
        return r;
    endfunction

    function automatic logic signed [15:0] scale_sample(input int x, input logic [63:0] d);
        int          m;
        logic [63:0] y;
        logic [63:0] frac;
        logic [63:0] r;
        logic [63:0] mag;
        logic [63:0] prod;
        logic [63:0] res;
        logic [63:0] cap;
        longint      lg;
        longint      e;
        longint      ip;
        longint      fr;
        longint      sh;
        if (x == 0)
        begin
            return 16'sd0;
        end
        m = 0;
        frac = 64'd0;
        while (m < 63 && (d >> (m + 1)) != 0)
        begin
            m++;
        end
        y = (m <= 30) ? (d << (30 - m)) : (d >> (m - 30));
        // Sixteen squarings give sixteen fraction bits of the logarithm.
        for (int i = 0; i < 16; i++)
        begin
            y = (y * y) >> 30;
            frac = frac << 1;
            if (y >= (64'd2 << 30))
            begin
                y = y >> 1;
                frac = frac | 64'd1;
            end
        end
        lg = (longint'(m) - 16) * 65536 + longint'(frac);
        e = -((longint'(beta_reg) * lg) >>> 14);
        ip = e >>> 16;
        fr = e - ip * 65536;
        r = 64'd1 << 30;
        for (int i = 1; i <= 16; i++)
        begin
            if (((fr >> (16 - i)) & 1) != 0)
            begin
                r = (r * root_q[i]) >> 30;
            end
        end
        mag = (x < 0) ? 64'(-x) : 64'(x);
        cap = (x < 0) ? 64'd32768 : 64'd32767;
        prod = mag * r;
        sh = 30 - ip;
        if (sh <= 0)
        begin
            res = cap;
        end
        else if (sh >= 63)
        begin
            res = 64'd0;
        end
        else
        begin
            res = (prod + (64'd1 << (sh - 1))) >> sh;
        end
        if (res > cap)
        begin
            res = cap;
        end
        return (x < 0) ? 16'(-res) : 16'(res);
    endfunction

    function automatic logic signed [15:0] channel_result(input int p, input int ahead,
                                                          input int after, input int size);
        int          lo;
        int          hi;
        logic [63:0] sum;
        logic [63:0] d;
        int          s;
        lo = (p > after) ? p - after : 0;
        hi = p + ahead;
        sum = 64'd0;
        if (seen_count == 0)
        begin
            return 16'sd0;
        end
        if (hi > seen_count - 1)
        begin
            hi = seen_count - 1;
        end
        if (hi > DEPTH - 1)
        begin
            hi = DEPTH - 1;
        end
        for (int i = lo; i <= hi; i++)
        begin
            s = int'($signed(history[i]));
            sum = sum + 64'(longint'(s) * s);
        end
        d = 64'(bias_reg) + (((64'(alpha_reg) * sum) / size) >> 24);
        if (d == 0)
        begin
            d = 64'd1;
        end
        return scale_sample(int'($signed(history[p])), d);
    endfunction

    // Advances the model by one accepted channel and queues what it releases.
    function automatic void predict_channel(input channel_item_t it);
        int           size;
        int           ahead;
        int           after;
        norm_result_t res;
        size = (win_reg == 0) ? 1 : int'(win_reg);
        ahead = (size - 1) / 2;
        after = size - 1 - ahead;
        for (int i = DEPTH - 1; i > 0; i--)
        begin
            history[i] = history[i - 1];
        end
        history[0] = it.sample;
        if (seen_count < 15)
        begin
            seen_count++;
        end
        if (waiting_count < 15)
        begin
            waiting_count++;
        end
        if (waiting_count > after + 1)
        begin
            waiting_count = after + 1;
        end
        if (it.last_channel)
        begin
            for (int p = waiting_count; p > 0; p--)
            begin
                res.normalized = channel_result(p - 1, ahead, after, size);
                res.last = (p == 1);
                expected_results.push_back(res);
            end
            waiting_count = 0;
            seen_count = 0;
        end
        else if (waiting_count > after)
        begin
            res.normalized = channel_result(waiting_count - 1, ahead, after, size);
            res.last = 1'b0;
            expected_results.push_back(res);
            waiting_count--;
        end
    endfunction

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sd0;
            3, 4, 5: return 16'($signed($urandom_range(0, 1024)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void queue_vector(input int len);
        channel_item_t it;
        for (int i = 0; i < len; i++)
        begin
            it.sample = pick_sample();
            it.last_channel = (i == len - 1);
            channel_queue.push_back(it);
        end
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [23:0] value);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            REG_WINDOW_SIZE: win_reg = value[3:0];
            REG_ALPHA_SCALE: alpha_reg = value;
            REG_BETA_EXP:    beta_reg = value[15:0];
            default:         bias_reg = value;
        endcase
        seen_count = 0;
        waiting_count = 0;
    endtask

    task automatic drain();
        do
        begin
            @(posedge clk);
        end
        while (channel_queue.size() != 0 || in_if.valid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_regs(input logic [3:0] w, input logic [23:0] a,
                            input logic [15:0] b, input logic [23:0] c);
        write_reg(REG_WINDOW_SIZE, {20'd0, w});
        write_reg(REG_ALPHA_SCALE, a);
        write_reg(REG_BETA_EXP, {8'd0, b});
        write_reg(REG_BIAS_OFFSET, c);
    endtask

    // Sender: keeps offering items, idling at random outside a calm stretch.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_if.valid && in_if.ready)
            begin
                predict_channel(offered);
                items_sent++;
            end
            if (!in_if.valid || in_if.ready)
            begin
                if (channel_queue.size() != 0
                    && ((items_sent > 120 && items_sent < 180) || $urandom_range(0, 99) >= 18))
                begin
                    offered = channel_queue.pop_front();
                    in_if.valid        <= 1'b1;
                    in_if.sample       <= offered.sample;
                    in_if.last_channel <= offered.last_channel;
                end
                else
                begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result transfer against the oldest expectation.
    always @(posedge clk)
    begin
        norm_result_t want;
        if (rst_n)
        begin
            if (out_if.valid && out_if.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("Unexpected result: normalized=%0d last=%0b",
                                 out_if.normalized, out_if.last);
                    end
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_if.normalized !== want.normalized || out_if.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("Result %0d: expected %0d/%0b, got %0d/%0b",
                                     results_checked, want.normalized, want.last,
                                     out_if.normalized, out_if.last);
                        end
                    end
                end
                results_checked++;
            end
            if (stall_left == 0 && !stall_done && results_checked >= 40)
            begin
                stall_left = 3000;
                stall_done = 1'b1;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_if.ready <= 1'b0;
            end
            else
            begin
                out_if.ready <= (results_checked > 150 && results_checked < 210)
                                || $urandom_range(0, 99) >= 18;
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        logic [63:0] t;
        clk = 1'b0;
        rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.sample = '0;
        in_if.last_channel = 1'b0;
        out_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        items_sent = 0;
        results_checked = 0;
        mismatches = 0;
        stall_left = 0;
        stall_done = 1'b0;
        win_reg = WINDOW_SIZE_RST;
        alpha_reg = ALPHA_SCALE_RST;
        beta_reg = BETA_EXP_RST;
        bias_reg = BIAS_OFFSET_RST;
        seen_count = 0;
        waiting_count = 0;
        for (int i = 0; i < DEPTH; i++)
        begin
            history[i] = 16'd0;
        end
        t = 64'd2 << 30;
        root_q[0] = t;
        for (int i = 1; i <= 16; i++)
        begin
            t = floor_sqrt(t << 30);
            root_q[i] = t;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset settings: extremes and a single-channel vector.
        channel_queue.push_back('{16'sh7fff, 1'b0});
        channel_queue.push_back('{16'sh8000, 1'b0});
        channel_queue.push_back('{16'sd0, 1'b0});
        channel_queue.push_back('{16'sd1, 1'b0});
        channel_queue.push_back('{-16'sd1, 1'b1});
        channel_queue.push_back('{16'sh8000, 1'b1});
        drain();

        // Widest window with the strongest terms, then a long vector that saturates.
        set_regs(4'd15, 24'hffffff, 16'hffff, 24'd1);
        channel_queue.push_back('{16'sh5555, 1'b0});
        channel_queue.push_back('{-16'sh5556, 1'b0});
        channel_queue.push_back('{16'sh7fff, 1'b1});
        queue_vector(18);
        drain();

        // Window size zero, zero bias and zero exponent; an all-zero vector.
        set_regs(4'd0, 24'd0, 16'd0, 24'd0);
        channel_queue.push_back('{16'sd0, 1'b0});
        channel_queue.push_back('{16'sd0, 1'b1});
        queue_vector(4);
        drain();

        set_regs(4'd0, 24'hffffff, 16'd12288, 24'hffffff);
        queue_vector(3);
        drain();

        // Random part: several random settings, random vector lengths.
        while (items_sent < 220)
        begin
            set_regs(4'($urandom_range(0, 15)), 24'($urandom),
                     ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20000)),
                     ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(1, 200000)));
            for (int n = 0; n < 6; n++)
            begin
                queue_vector(($urandom_range(0, 7) == 0) ? $urandom_range(15, 20)
                                                         : $urandom_range(1, 10));
            end
            drain();
        end

        $display("Covered %0d channel transfers and %0d result transfers", items_sent,
                 results_checked);
        $display("over extreme and random register settings, with stalls on both sides.");
        if (mismatches == 0 && expected_results.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
